>>> design/hmtvg_pkg.sv
// Shared constants and helpers for the heightmap terrain vertex generator.
package hmtvg_pkg;

  localparam int unsigned GRID_MAX_DEFAULT    = 256;
  localparam int unsigned HEIGHT_BITS_DEFAULT = 16;

  localparam logic [15:0] TILE_RESET = 16'd256;
  localparam logic [8:0]  GRID_RESET = 9'd256;

  localparam logic REG_TILE_WIDTH = 1'b0;
  localparam logic REG_GRID_WIDTH = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // squared magnitude of the 1.0 (Q8.8) up component, Q16.16
  localparam logic [31:0] ONE_SQ = 32'd65536;

  // saturate a height difference to +-65535; returns {negative, magnitude}
  function automatic logic [16:0] sat_abs(input logic signed [33:0] d);
    logic signed [33:0] s;
    begin
      if (d > 34'sd65535) begin
        s = 34'sd65535;
      end else if (d < -34'sd65535) begin
        s = -34'sd65535;
      end else begin
        s = d;
      end
      if (s < 0) begin
        return {1'b1, 16'(-s)};
      end
      return {1'b0, 16'(s)};
    end
  endfunction

endpackage

>>> design/hmtvg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hmtvg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/heightmap_terrain_vertex_gen.sv
// Heightmap terrain vertex generator: top level with sequencer and shared arithmetic.
//
// Input words (op, height) arrive on in_valid/in_stall in raster order; a word
// is taken when in_valid is high and in_stall low. Each height sample of row z
// yields the vertex of row z-1 at the same column; op=1 flush words drain the
// last row. Vertex words leave on out_valid/out_stall from an output register.
// Config writes (cfg_write, cfg_index, cfg_data) are taken at any edge with
// cfg_write high; writing grid_width restarts the frame.
// An item that yields a vertex goes through the row-buffer reads, 5 passes of
// the shared multiplier, the bit-serial normal search (15 steps per component,
// 3 components) and a 16-step divider for texture coordinates. A sample that
// yields no vertex only reads and writes the row buffers; an ignored word
// stays in S_IDLE. in_stall is high while an item is in work. The output
// register holds a word until taken; while it is stalled the next item still
// runs and waits in its final step for the register. Reset clears counters
// and out_valid and sets config to its defaults; row buffers need no clearing.
module heightmap_terrain_vertex_gen #(
  parameter int unsigned GRID_MAX    = hmtvg_pkg::GRID_MAX_DEFAULT,
  parameter int unsigned HEIGHT_BITS = hmtvg_pkg::HEIGHT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic signed [HEIGHT_BITS-1:0] height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [23:0]                   pos_x,
  output logic signed [15:0]            pos_y,
  output logic [23:0]                   pos_z,
  output logic signed [15:0]            norm_x,
  output logic [14:0]                   norm_y,
  output logic signed [15:0]            norm_z,
  output logic [15:0]                   tex_u,
  output logic [15:0]                   tex_v,
  output logic                          quad_valid,
  output logic [15:0]                   quad_base_index,
  output logic                          last,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int unsigned CW = $clog2(GRID_MAX);
  localparam int unsigned RW = $clog2(GRID_MAX + 1);
  localparam int unsigned HB = HEIGHT_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_RD3  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  state;
  logic [15:0] tile_width;
  logic [8:0]  grid_width;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          sel;

  // item registers
  logic              op_r;
  logic              emit_r;
  logic              down_ok;
  logic              left_ok;
  logic              right_ok;
  logic              last_r;
  logic              above_sel;
  logic [CW-1:0]     x_r;
  logic [RW-1:0]     zo_r;
  logic [RW-1:0]     w_r;
  logic signed [HB-1:0] h_r;
  logic signed [HB-1:0] left_v;
  logic signed [HB-1:0] right_v;
  logic signed [HB-1:0] down_v;
  logic signed [HB-1:0] y_v;
  logic              dxn;
  logic              dzn;
  logic [15:0]       dxa;
  logic [15:0]       dza;
  logic [31:0]       dx2;
  logic [31:0]       dz2;
  logic [23:0]       posx_r;
  logic [23:0]       posz_r;
  logic [15:0]       zw_r;
  logic [2:0]        mstep;
  logic [32:0]       s_r;
  logic [63:0]       t_r;
  logic [63:0]       p_r;
  logic [63:0]       q_r;
  logic [14:0]       m_r;
  logic [3:0]        k_r;
  logic [1:0]        comp;
  logic [14:0]       magx;
  logic [14:0]       magy;
  logic [14:0]       magz;
  logic [RW:0]       rem_u;
  logic [RW:0]       rem_v;
  logic [15:0]       qu;
  logic [15:0]       qv;
  logic [3:0]        dstep;

  // effective width and current column
  logic [RW-1:0] w_eff;
  logic [RW-1:0] wm1;
  logic [RW-1:0] col_ext;
  logic [RW-1:0] x_cur;
  logic [CW-1:0] x_now;
  logic [RW-1:0] x_inc;

  always_comb begin
    if (grid_width < 9'd2) begin
      w_eff = RW'(2);
    end else if (32'(grid_width) > 32'(GRID_MAX)) begin
      w_eff = RW'(GRID_MAX);
    end else begin
      w_eff = RW'(grid_width);
    end
    wm1     = w_eff - RW'(1);
    col_ext = RW'(col);
    x_cur   = (col_ext > wm1) ? wm1 : col_ext;
    x_now   = CW'(x_cur);
    x_inc   = x_cur + RW'(1);
  end

  logic accept;
  logic out_load;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // row buffers, swapped by bank select
  logic [CW-1:0] ab_addr;
  logic [CW-1:0] raddr0;
  logic [CW-1:0] raddr1;
  logic [HB-1:0] rd0;
  logic [HB-1:0] rd1;
  logic          we0;
  logic          we1;
  logic          wr;
  logic signed [HB-1:0] rd_above;
  logic signed [HB-1:0] rd_cur;

  always_comb begin
    case (state)
      S_RD0:   ab_addr = left_ok ? x_r - CW'(1) : x_r;
      S_RD1:   ab_addr = right_ok ? x_r + CW'(1) : x_r;
      default: ab_addr = x_r;
    endcase
  end

  assign raddr0   = above_sel ? x_r : ab_addr;
  assign raddr1   = above_sel ? ab_addr : x_r;
  assign rd_above = above_sel ? rd1 : rd0;
  assign rd_cur   = above_sel ? rd0 : rd1;
  assign wr       = (state == S_RD3) && (op_r == hmtvg_pkg::OP_SAMPLE);
  assign we0      = wr && above_sel;
  assign we1      = wr && !above_sel;

  hmtvg_ram #(.WIDTH(HB), .DEPTH(GRID_MAX)) u_bank0 (
    .clk(clk), .we(we0), .waddr(x_r), .wdata(h_r), .raddr(raddr0), .rdata(rd0)
  );

  hmtvg_ram #(.WIDTH(HB), .DEPTH(GRID_MAX)) u_bank1 (
    .clk(clk), .we(we1), .waddr(x_r), .wdata(h_r), .raddr(raddr1), .rdata(rd1)
  );

  // differences
  logic signed [HB-1:0] up_v;
  logic [16:0] dx_sa;
  logic [16:0] dz_sa;

  assign up_v  = (op_r == hmtvg_pkg::OP_SAMPLE) ? h_r : '0;
  assign dx_sa = hmtvg_pkg::sat_abs(34'(left_v) - 34'(right_v));
  assign dz_sa = hmtvg_pkg::sat_abs(34'(down_v) - 34'(up_v));

  // shared multiplier
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] mul_p;

  always_comb begin
    case (mstep)
      3'd0: begin
        mul_a = 17'(dxa);
        mul_b = 17'(dxa);
      end
      3'd1: begin
        mul_a = 17'(dza);
        mul_b = 17'(dza);
      end
      3'd2: begin
        mul_a = 17'(x_r);
        mul_b = 17'(tile_width);
      end
      3'd3: begin
        mul_a = 17'(zo_r);
        mul_b = 17'(tile_width);
      end
      default: begin
        mul_a = 17'(zo_r);
        mul_b = 17'(w_r);
      end
    endcase
    mul_p = 34'(mul_a) * 34'(mul_b);
  end

  // normal search step
  logic [64:0] cand;
  logic        take;
  logic [14:0] m_new;

  always_comb begin
    cand  = 65'(p_r) + (65'(q_r) << (5'(k_r) + 5'd1)) + (65'(s_r) << {k_r, 1'b0});
    take  = cand <= 65'(t_r);
    m_new = m_r;
    if (take) begin
      m_new[k_r] = 1'b1;
    end
  end

  // divider step
  logic [RW+1:0] ru2;
  logic [RW+1:0] rv2;
  logic          bu;
  logic          bv;

  always_comb begin
    ru2 = {rem_u, 1'b0};
    rv2 = {rem_v, 1'b0};
    bu  = ru2 >= (RW + 2)'(w_r);
    bv  = rv2 >= (RW + 2)'(w_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tile_width <= hmtvg_pkg::TILE_RESET;
      grid_width <= hmtvg_pkg::GRID_RESET;
      col        <= '0;
      row        <= '0;
      sel        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          hmtvg_pkg::REG_TILE_WIDTH: tile_width <= cfg_data;
          hmtvg_pkg::REG_GRID_WIDTH: begin
            grid_width <= cfg_data[8:0];
            col        <= '0;
            row        <= '0;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r      <= op;
            h_r       <= height;
            x_r       <= x_now;
            w_r       <= w_eff;
            above_sel <= sel;
            left_ok   <= x_cur != '0;
            right_ok  <= x_inc < w_eff;
            if (op == hmtvg_pkg::OP_SAMPLE) begin
              if (row < w_eff) begin
                state   <= S_RD0;
                emit_r  <= row != '0;
                zo_r    <= row - RW'(1);
                down_ok <= row >= RW'(2);
                last_r  <= 1'b0;
                if (x_inc >= w_eff) begin
                  col <= '0;
                  row <= row + RW'(1);
                  sel <= !sel;
                end else begin
                  col <= CW'(x_inc);
                end
              end
            end else begin
              if (row >= w_eff) begin
                state   <= S_RD0;
                emit_r  <= 1'b1;
                zo_r    <= wm1;
                down_ok <= 1'b1;
                last_r  <= x_inc >= w_eff;
                if (x_inc >= w_eff) begin
                  col <= '0;
                  row <= '0;
                end else begin
                  col <= CW'(x_inc);
                end
              end
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          left_v <= left_ok ? rd_above : '0;
          down_v <= down_ok ? rd_cur : '0;
          state  <= S_RD2;
        end
        S_RD2: begin
          right_v <= right_ok ? rd_above : '0;
          state   <= S_RD3;
        end
        S_RD3: begin
          y_v   <= rd_above;
          dxn   <= dx_sa[16];
          dxa   <= dx_sa[15:0];
          dzn   <= dz_sa[16];
          dza   <= dz_sa[15:0];
          mstep <= 3'd0;
          state <= emit_r ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          case (mstep)
            3'd0:    dx2    <= mul_p[31:0];
            3'd1:    dz2    <= mul_p[31:0];
            3'd2:    posx_r <= mul_p[23:0];
            3'd3:    posz_r <= mul_p[23:0];
            default: zw_r   <= mul_p[15:0];
          endcase
          mstep <= mstep + 3'd1;
          if (mstep == 3'd4) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          s_r   <= 33'(dx2) + 33'(dz2) + 33'(hmtvg_pkg::ONE_SQ);
          t_r   <= 64'(dx2) << 30;
          p_r   <= '0;
          q_r   <= '0;
          m_r   <= '0;
          k_r   <= 4'd14;
          comp  <= 2'd0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (k_r == 4'd0) begin
            p_r <= '0;
            q_r <= '0;
            m_r <= '0;
            k_r <= 4'd14;
            comp <= comp + 2'd1;
            case (comp)
              2'd0: begin
                magx <= m_new;
                t_r  <= 64'(hmtvg_pkg::ONE_SQ) << 30;
              end
              2'd1: begin
                magy <= m_new;
                t_r  <= 64'(dz2) << 30;
              end
              default: begin
                magz  <= m_new;
                rem_u <= (RW + 1)'(x_r);
                rem_v <= (RW + 1)'(zo_r);
                dstep <= 4'd15;
                state <= S_DIV;
              end
            endcase
          end else begin
            if (take) begin
              p_r <= cand[63:0];
              q_r <= q_r + (64'(s_r) << k_r);
            end
            m_r <= m_new;
            k_r <= k_r - 4'd1;
          end
        end
        S_DIV: begin
          rem_u <= bu ? (RW + 1)'(ru2 - (RW + 2)'(w_r)) : (RW + 1)'(ru2);
          rem_v <= bv ? (RW + 1)'(rv2 - (RW + 2)'(w_r)) : (RW + 1)'(rv2);
          qu    <= {qu[14:0], bu};
          qv    <= {qv[14:0], bv};
          dstep <= dstep - 4'd1;
          if (dstep == 4'd0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  logic qvalid_c;
  assign qvalid_c = ((RW + 1)'(x_r) + (RW + 1)'(1) < (RW + 1)'(w_r))
                 && ((RW + 1)'(zo_r) + (RW + 1)'(1) < (RW + 1)'(w_r));

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x           <= posx_r;
      pos_y           <= 16'(y_v);
      pos_z           <= posz_r;
      norm_x          <= dxn ? -16'({1'b0, magx}) : 16'({1'b0, magx});
      norm_y          <= magy;
      norm_z          <= dzn ? -16'({1'b0, magz}) : 16'({1'b0, magz});
      tex_u           <= qu;
      tex_v           <= qv;
      quad_valid      <= qvalid_c;
      quad_base_index <= qvalid_c ? zw_r + 16'(x_r) : 16'd0;
      last            <= last_r;
    end
  end

endmodule

>>> design/hmtvg_checker.sv
// Port-level assertions for the heightmap terrain vertex generator, with bind.
module hmtvg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] pos_x,
  input logic        quad_valid,
  input logic [15:0] quad_base_index,
  input logic        last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(last))
    else $error("stalled word changed");

  a_last_no_quad: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !quad_valid)
    else $error("final vertex marked as quad start");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !quad_valid |-> quad_base_index == 16'd0)
    else $error("quad index set without quad");

endmodule

bind heightmap_terrain_vertex_gen hmtvg_checker u_hmtvg_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .pos_x(pos_x),
  .quad_valid(quad_valid),
  .quad_base_index(quad_base_index),
  .last(last)
);
